// ===== rtl/ywr_pkg.sv =====
// Shared types, constants and the arctangent table of the yaw-rate step block.
// No dependencies; every other file imports this package.
package ywr_pkg;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int IT_W = $clog2(ANGLE_ITERATIONS);

  localparam int CFG_W = 16;
  localparam int IDX_W = 3;
  localparam int DT_W  = 24;
  localparam int ANG_W = 16;
  localparam int YAW_W = 24;

  localparam int MUL_W = 33;
  localparam int PRD_W = 2 * MUL_W;
  localparam int MAG_W = 53;
  localparam int P_W   = MAG_W + DT_W;
  localparam int REM_W = 61;
  localparam int DW_W  = 26;

  localparam logic [IDX_W-1:0] REG_BOAT_SPEED     = 3'd0;
  localparam logic [IDX_W-1:0] REG_TURNING_MOMENT = 3'd1;
  localparam logic [IDX_W-1:0] REG_RUDDER_GAIN    = 3'd2;
  localparam logic [IDX_W-1:0] REG_FRICTION_LIN   = 3'd3;
  localparam logic [IDX_W-1:0] REG_FRICTION_QUAD  = 3'd4;

  localparam logic [CFG_W-1:0] RST_TURNING_MOMENT = 16'd5000;
  localparam logic [CFG_W-1:0] RST_RUDDER_GAIN    = 16'd1500;
  localparam logic [CFG_W-1:0] RST_FRICTION_LIN   = 16'd200;
  localparam logic [CFG_W-1:0] RST_FRICTION_QUAD  = 16'd1000;

  localparam logic signed [33:0] Q30_HALF_PI     = 34'sd1686629713;
  localparam logic signed [33:0] Q30_PI          = 34'sd3373259426;
  localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
  localparam logic [19:0]        US_PER_S        = 20'd1000000;
  localparam logic signed [26:0] YAW_MAX         = 27'sd8388607;
  localparam logic signed [26:0] YAW_MIN         = -27'sd8388608;

  typedef struct packed {
    logic [CFG_W-1:0] boat_speed;
    logic [CFG_W-1:0] turning_moment;
    logic [CFG_W-1:0] rudder_gain;
    logic [CFG_W-1:0] friction_linear;
    logic [CFG_W-1:0] friction_quadratic;
  } cfg_t;

  // atan(2^-i) in Q30, rounded to nearest; small angles fall back to 2^-i
  function automatic logic signed [33:0] atan_step(input logic [31:0] i);
    logic signed [33:0] r;
    case (i)
      32'd0:   r = 34'sd843314857;
      32'd1:   r = 34'sd497837829;
      32'd2:   r = 34'sd263043837;
      32'd3:   r = 34'sd133525159;
      32'd4:   r = 34'sd67021687;
      32'd5:   r = 34'sd33543516;
      32'd6:   r = 34'sd16775851;
      32'd7:   r = 34'sd8388437;
      32'd8:   r = 34'sd4194283;
      32'd9:   r = 34'sd2097149;
      default: r = (i > 32'd30) ? 34'sd0 : (34'sd1 <<< (32'd30 - i));
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ywr_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on ywr_pkg for the operand width.
module ywr_mul (
  input  logic                               clk_i,
  input  logic signed [ywr_pkg::MUL_W-1:0]   a_i,
  input  logic signed [ywr_pkg::MUL_W-1:0]   b_i,
  output logic signed [ywr_pkg::PRD_W-1:0]   p_o
);
  import ywr_pkg::*;

  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

// ===== rtl/ywr_core.sv =====
// Sequencer and datapath of one yaw-rate step: CORDIC, products on the shared
// multiplier, saturation check and restoring division. Uses ywr_pkg, ywr_mul.
module ywr_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ywr_pkg::cfg_t               cfg_i,
  input  logic                        start_i,
  input  logic [ywr_pkg::DT_W-1:0]    time_step_i,
  input  logic [ywr_pkg::ANG_W-1:0]   rudder_angle_i,
  input  logic                        out_free_i,
  output logic                        ready_o,
  output logic                        done_o,
  output logic [ywr_pkg::YAW_W-1:0]   yaw_rate_o
);
  import ywr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CORDIC, S_MG, S_MWC, S_MSQ, S_MTR, S_MFL, S_MFQ, S_MDEN,
    S_MLO, S_MHI, S_PSUM, S_CMP, S_DIV, S_FIN, S_DONE
  } state_e;

  state_e                    state_q;
  logic [IT_W-1:0]           it_q;
  logic [4:0]                k_q;
  logic [DT_W-1:0]           dt_q;
  logic signed [YAW_W-1:0]   w_q;
  logic [YAW_W-1:0]          res_q;
  logic signed [32:0]        x_q, y_q;
  logic signed [33:0]        z_q;
  logic                      flip_q;
  logic [31:0]               g_q;
  logic signed [26:0]        inner_q;
  logic [26:0]               sq_q;
  logic signed [51:0]        tr_q;
  logic [43:0]               tw_q;
  logic [MAG_W-1:0]          mag_q;
  logic                      t_neg_q;
  logic [35:0]               denom_q;
  logic [P_W-1:0]            prod_q;
  logic [REM_W-1:0]          rem_q;
  logic [DW_W-1:0]           dw_q;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PRD_W-1:0]   mul_p;

  logic signed [33:0]        z_in;
  logic signed [32:0]        dx, dy, cs;
  logic signed [45:0]        wc;
  logic signed [46:0]        inner_full;
  logic [24:0]               aw;
  logic [15:0]               mz;
  logic [43:0]               tw_sum;
  logic signed [52:0]        t_sum;
  logic [REM_W-1:0]          denom_top, trial;
  logic signed [26:0]        nw;
  logic signed [26:0]        nw_sat;

  ywr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  always_comb begin
    z_in       = 34'(signed'(rudder_angle_i)) <<< 16;
    dx         = y_q >>> it_q;
    dy         = x_q >>> it_q;
    cs         = flip_q ? -x_q : x_q;
    wc         = mul_p[65:20];
    inner_full = 47'(y_q) - 47'(wc);
    aw         = w_q[YAW_W-1] ? 25'(-26'(w_q)) : 25'(w_q);
    mz         = (cfg_i.turning_moment == '0) ? 16'd1 : cfg_i.turning_moment;
    tw_sum     = tw_q + 44'(unsigned'(mul_p[42:0]));
    t_sum      = (w_q > 0) ? 53'(tr_q) - 53'(tw_sum) : 53'(tr_q) + 53'(tw_sum);
    denom_top  = {denom_q, 25'd0};
    trial      = {25'd0, denom_q} << k_q;
    nw         = t_neg_q ? 27'(w_q) - 27'(dw_q) : 27'(w_q) + 27'(dw_q);
    if (nw > YAW_MAX) begin
      nw_sat = YAW_MAX;
    end else if (nw < YAW_MIN) begin
      nw_sat = YAW_MIN;
    end else begin
      nw_sat = nw;
    end

    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MG: begin
        mul_a = MUL_W'(cfg_i.rudder_gain);
        mul_b = MUL_W'(cfg_i.boat_speed);
      end
      S_MWC: begin
        mul_a = MUL_W'(w_q);
        mul_b = cs;
      end
      S_MSQ: begin
        mul_a = MUL_W'(aw);
        mul_b = MUL_W'(aw);
      end
      S_MTR: begin
        mul_a = MUL_W'(g_q);
        mul_b = MUL_W'(inner_q);
      end
      S_MFL: begin
        mul_a = MUL_W'(cfg_i.friction_linear);
        mul_b = MUL_W'(aw);
      end
      S_MFQ: begin
        mul_a = MUL_W'(cfg_i.friction_quadratic);
        mul_b = MUL_W'(sq_q);
      end
      S_MDEN: begin
        mul_a = MUL_W'(mz);
        mul_b = MUL_W'(US_PER_S);
      end
      S_MLO: begin
        mul_a = MUL_W'(mag_q[25:0]);
        mul_b = MUL_W'(dt_q);
      end
      S_MHI: begin
        mul_a = MUL_W'(mag_q[MAG_W-1:26]);
        mul_b = MUL_W'(dt_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      it_q    <= '0;
      k_q     <= '0;
      dt_q    <= '0;
      w_q     <= '0;
      res_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      flip_q  <= 1'b0;
      g_q     <= '0;
      inner_q <= '0;
      sq_q    <= '0;
      tr_q    <= '0;
      tw_q    <= '0;
      mag_q   <= '0;
      t_neg_q <= 1'b0;
      denom_q <= '0;
      prod_q  <= '0;
      rem_q   <= '0;
      dw_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            dt_q <= time_step_i;
            it_q <= '0;
            x_q  <= CORDIC_GAIN_Q30;
            y_q  <= '0;
            if (cfg_i.boat_speed == '0) begin
              w_q     <= '0;
              res_q   <= '0;
              state_q <= S_DONE;
            end else begin
              // fold the angle into (-pi/2, pi/2], remember to negate cos
              if (z_in > Q30_HALF_PI) begin
                z_q    <= Q30_PI - z_in;
                flip_q <= 1'b1;
              end else if (z_in < -Q30_HALF_PI) begin
                z_q    <= -Q30_PI - z_in;
                flip_q <= 1'b1;
              end else begin
                z_q    <= z_in;
                flip_q <= 1'b0;
              end
              state_q <= S_CORDIC;
            end
          end
        end
        S_CORDIC: begin
          if (z_q >= 0) begin
            x_q <= x_q - dx;
            y_q <= y_q + dy;
            z_q <= z_q - atan_step(32'(it_q));
          end else begin
            x_q <= x_q + dx;
            y_q <= y_q - dy;
            z_q <= z_q + atan_step(32'(it_q));
          end
          if (it_q == IT_W'(ANGLE_ITERATIONS - 1)) begin
            state_q <= S_MG;
          end else begin
            it_q <= it_q + 1'b1;
          end
        end
        S_MG:  state_q <= S_MWC;
        S_MWC: begin
          g_q     <= mul_p[31:0];
          state_q <= S_MSQ;
        end
        S_MSQ: begin
          inner_q <= 27'(inner_full >>> 10);
          state_q <= S_MTR;
        end
        S_MTR: begin
          sq_q    <= mul_p[46:20];
          state_q <= S_MFL;
        end
        S_MFL: begin
          tr_q    <= mul_p[59:8];
          state_q <= S_MFQ;
        end
        S_MFQ: begin
          tw_q    <= 44'(unsigned'(mul_p[39:0]));
          state_q <= S_MDEN;
        end
        S_MDEN: begin
          t_neg_q <= t_sum[52];
          mag_q   <= t_sum[52] ? MAG_W'(-t_sum) : MAG_W'(t_sum);
          state_q <= S_MLO;
        end
        S_MLO: begin
          denom_q <= mul_p[35:0];
          state_q <= S_MHI;
        end
        S_MHI: begin
          prod_q  <= P_W'(unsigned'(mul_p[49:0]));
          state_q <= S_PSUM;
        end
        S_PSUM: begin
          prod_q  <= prod_q + (P_W'(unsigned'(mul_p[50:0])) << 26);
          state_q <= S_CMP;
        end
        S_CMP: begin
          // saturate when mag*dt exceeds 2^25 * denominator
          if (dt_q == '0 || mag_q == '0) begin
            dw_q    <= '0;
            state_q <= S_FIN;
          end else if (prod_q > P_W'(denom_top)) begin
            dw_q    <= DW_W'(1) << 25;
            state_q <= S_FIN;
          end else begin
            rem_q   <= prod_q[REM_W-1:0];
            dw_q    <= '0;
            k_q     <= 5'd25;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_q >= trial) begin
            rem_q       <= rem_q - trial;
            dw_q[k_q]   <= 1'b1;
          end
          if (k_q == 5'd0) begin
            state_q <= S_FIN;
          end else begin
            k_q <= k_q - 1'b1;
          end
        end
        S_FIN: begin
          w_q     <= YAW_W'(nw_sat);
          res_q   <= YAW_W'(nw_sat);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign ready_o    = (state_q == S_IDLE);
  assign done_o     = (state_q == S_DONE) && out_free_i;
  assign yaw_rate_o = res_q;

`ifndef SYNTHESIS
  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start_i) |=> (state_q != S_IDLE))
    else $error("accepted request did not start a step");
  a_done_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (state_q == S_IDLE))
    else $error("sequencer did not return to idle after delivery");
  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q <= denom_top))
    else $error("division remainder out of range");
  a_done_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |=> (state_q == S_DONE && w_q == $signed(res_q)))
    else $error("result register and yaw state disagree");
`endif

endmodule

// ===== rtl/boat_yaw_rate_step_top.sv =====
// Top level of the boat yaw-rate step: configuration registers, request
// handshake and result register around ywr_core. Uses ywr_pkg.
//
// Each request (time step, rudder angle) advances the stored yaw rate by one
// Euler step and yields one saturated yaw rate. With the rate change divided
// out, a request runs ANGLE_ITERATIONS (16) CORDIC iterations for sine and
// cosine, nine passes through the one shared multiplier plus the product sum
// and the saturation check, 26 restoring-division steps, and the finish and
// deliver states. A zero time step, a zero torque or a rate change that
// saturates skips the division; a zero boat speed goes straight to delivery.
// in_stall_o is high while a step is in progress. The result register lets
// the next request start while a result is still waiting to be taken; a
// second finished result holds the core until the first one is taken. The
// user must write registers through cfg_wr_en_i / cfg_index_i / cfg_data_i
// only while the block is idle; the block itself does not enforce it.
module boat_yaw_rate_step_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_wr_en_i,
  input  logic [ywr_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [ywr_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [ywr_pkg::DT_W-1:0]    time_step_i,
  input  logic signed [ywr_pkg::ANG_W-1:0] rudder_angle_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [ywr_pkg::YAW_W-1:0] yaw_rate_o
);
  import ywr_pkg::*;

  cfg_t              cfg_q;
  logic              ready, done, out_free, out_valid_q;
  logic [YAW_W-1:0]  core_yaw, yaw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.boat_speed         <= '0;
      cfg_q.turning_moment     <= RST_TURNING_MOMENT;
      cfg_q.rudder_gain        <= RST_RUDDER_GAIN;
      cfg_q.friction_linear    <= RST_FRICTION_LIN;
      cfg_q.friction_quadratic <= RST_FRICTION_QUAD;
    end else if (cfg_wr_en_i) begin
      case (cfg_index_i)
        REG_BOAT_SPEED:     cfg_q.boat_speed         <= cfg_data_i;
        REG_TURNING_MOMENT: cfg_q.turning_moment     <= cfg_data_i;
        REG_RUDDER_GAIN:    cfg_q.rudder_gain        <= cfg_data_i;
        REG_FRICTION_LIN:   cfg_q.friction_linear    <= cfg_data_i;
        REG_FRICTION_QUAD:  cfg_q.friction_quadratic <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  ywr_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .start_i        (in_valid_i),
    .time_step_i    (time_step_i),
    .rudder_angle_i (rudder_angle_i),
    .out_free_i     (out_free),
    .ready_o        (ready),
    .done_o         (done),
    .yaw_rate_o     (core_yaw)
  );

  // load a new result, or drop the one just taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      yaw_q       <= '0;
    end else if (done) begin
      out_valid_q <= 1'b1;
      yaw_q       <= core_yaw;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_stall_o  = !ready;
  assign out_valid_o = out_valid_q;
  assign yaw_rate_o  = signed'(yaw_q);

endmodule

// ===== bench/tb_boat_yaw_rate_step_top.sv =====
// Self-checking bench for boat_yaw_rate_step_top: a predictor of the yaw-rate
// Euler step checks each result in order. Depends on ywr_pkg and the block.
module tb_boat_yaw_rate_step_top;
  import ywr_pkg::*;

  localparam int HOLD_OFF   = 400;
  localparam int WDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_wr_en_i = 1'b0;
  logic [IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [DT_W-1:0] time_step_i = '0;
  logic signed [ANG_W-1:0] rudder_angle_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [YAW_W-1:0] yaw_rate_o;

  boat_yaw_rate_step_top dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  logic [15:0] speed_m, moment_m, gain_m, flin_m, fquad_m;
  longint yaw_m;
  logic signed [YAW_W-1:0] yaw_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_rx = 1'b0;
  bit quiet_rx = 1'b0;

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_q30(int i);
    longint t[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                      33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return t[i];
    if (i > 30) return 0;
    return longint'(1) << (30 - i);
  endfunction

  function automatic logic signed [YAW_W-1:0] next_yaw(logic [DT_W-1:0] dt,
                                                      logic signed [ANG_W-1:0] ang);
    longint z, x, y, dx, dy, sn, cs, inner, tr, tw, t, nw, w;
    longint unsigned aw, mag, den, lim, dw, mz;
    bit flip;
    w = yaw_m;
    if (speed_m == 0) begin
      yaw_m = 0;
      return '0;
    end
    z = longint'(ang) * 65536;
    flip = 0;
    x = 652032874;
    y = 0;
    if (z > 64'sd1686629713) begin
      z = 64'sd3373259426 - z;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z = -64'sd3373259426 - z;
      flip = 1;
    end
    for (int i = 0; i < ANGLE_ITERATIONS; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q30(i);
      end else begin
        x += dx; y -= dy; z += atan_q30(i);
      end
    end
    sn = y;
    cs = flip ? -x : x;
    inner = shr(sn - shr(w * cs, 20), 10);
    tr = shr(longint'(longint'(gain_m) * longint'(speed_m)) * inner, 8);
    aw = (w < 0) ? -w : w;
    tw = flin_m * aw + fquad_m * ((aw * aw) >> 20);
    if (w > 0) tw = -tw;
    t = tr + tw;
    mag = (t < 0) ? -t : t;
    mz = (moment_m == 0) ? 1 : moment_m;
    den = mz * 1000000;
    lim = 64'd33554432 * den;
    if (dt == 0 || mag == 0) dw = 0;
    else if (mag > lim / dt) dw = 33554432;
    else dw = (mag * dt) / den;
    nw = (t < 0) ? w - longint'(dw) : w + longint'(dw);
    if (nw > 8388607) nw = 8388607;
    if (nw < -8388608) nw = -8388608;
    yaw_m = nw;
    return nw[YAW_W-1:0];
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    case (idx)
      REG_BOAT_SPEED:     speed_m = val;
      REG_TURNING_MOMENT: moment_m = val;
      REG_RUDDER_GAIN:    gain_m = val;
      REG_FRICTION_LIN:   flin_m = val;
      REG_FRICTION_QUAD:  fquad_m = val;
      default: ;
    endcase
  endtask

  // drop the request, then hold until every result has arrived and the core
  // has drained
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (yaw_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // the request stays up after acceptance; the caller drops it before a pause
  task automatic send_step(logic [DT_W-1:0] dt, logic signed [ANG_W-1:0] ang);
    in_valid_i     <= 1'b1;
    time_step_i    <= dt;
    rudder_angle_i <= ang;
    do @(posedge clk_i); while (in_stall_o);
    yaw_q.push_back(next_yaw(dt, ang));
  endtask

  task automatic set_all(logic [15:0] s, logic [15:0] m, logic [15:0] g,
                         logic [15:0] fl, logic [15:0] fq);
    wait_drained();
    write_reg(REG_BOAT_SPEED, s);
    write_reg(REG_TURNING_MOMENT, m);
    write_reg(REG_RUDDER_GAIN, g);
    write_reg(REG_FRICTION_LIN, fl);
    write_reg(REG_FRICTION_QUAD, fq);
  endtask

  function automatic logic [DT_W-1:0] rand_dt();
    case ($urandom_range(0, 4))
      0: return DT_W'($urandom_range(0, 255));
      1: return DT_W'($urandom());
      2: return DT_W'($urandom_range(50000, 150000));
      default: return DT_W'($urandom_range(0, 20000));
    endcase
  endfunction

  task automatic test_directed();
    send_step(24'd100000, 16'sd1000);      // zero speed after reset
    set_all(16'd256, 16'd5000, 16'd1500, 16'd200, 16'd1000);
    send_step(24'd0, 16'sd4000);           // zero time step
    send_step(24'hFFFFFF, 16'sh7FFF);
    send_step(24'hFFFFFF, 16'sh8000);
    send_step(24'd100000, 16'sd0);
    send_step(24'd100000, 16'sd25736);     // near +pi/2
    send_step(24'd100000, -16'sd25736);
    send_step(24'd100000, 16'sd30000);     // reflected angles
    send_step(24'd100000, -16'sd30000);
    set_all(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // moment of zero
    send_step(24'hFFFFFF, 16'sd12000);     // saturate high
    send_step(24'hFFFFFF, -16'sd12000);
    send_step(24'hFFFFFF, -16'sd20000);    // saturate low
    send_step(24'd1, 16'sd5);
    set_all(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0);
    send_step(24'd123456, 16'sd100);
  endtask

  task automatic test_random(int count);
    int left, gap;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 99) < 3) begin
        set_all($urandom_range(0, 9) == 0 ? 16'd0 : 16'($urandom()),
                16'($urandom()), 16'($urandom()), 16'($urandom()),
                16'($urandom()));
      end
      for (int b = $urandom_range(1, 12); b > 0 && left > 0; b--) begin
        send_step(rand_dt(), 16'($urandom()));
        left--;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 80);
      if (gap > 0) in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic test_backpressure();
    set_all(16'd512, 16'd3000, 16'd2000, 16'd300, 16'd800);
    hold_rx = 1'b1;
    for (int k = 0; k < 6; k++) send_step(rand_dt(), 16'($urandom()));
    hold_rx = 1'b0;
    wait_drained();
    quiet_rx = 1'b1;
    for (int k = 0; k < 20; k++) send_step(rand_dt(), 16'($urandom()));
    quiet_rx = 1'b0;
  endtask

  // receiver stall pattern and long hold-off
  always @(posedge clk_i) begin
    int hold_cnt;
    if (hold_rx && hold_cnt < HOLD_OFF) begin
      hold_cnt <= hold_cnt + 1;
      out_stall_i <= 1'b1;
    end else begin
      if (!hold_rx) hold_cnt <= 0;
      out_stall_i <= quiet_rx ? 1'b0 : ($urandom_range(0, 3) == 0);
    end
  end

  // check each result against the oldest expectation
  always @(posedge clk_i) begin
    logic signed [YAW_W-1:0] exp_yaw;
    if (rst_ni && (in_valid_i && !in_stall_o || out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (yaw_q.size() == 0) begin
        $error("yaw_rate: unexpected result %0d", yaw_rate_o);
        errors++;
      end else begin
        exp_yaw = yaw_q.pop_front();
        if (yaw_rate_o !== exp_yaw) begin
          $error("yaw_rate: expected %0d, actual %0d", exp_yaw, yaw_rate_o);
          errors++;
        end
      end
    end
    if (idle_cycles > WDOG_LIMIT) begin
      $display("tb_boat_yaw_rate_step_top failed");
      $finish;
    end
  end

  initial begin
    speed_m = 0;
    moment_m = RST_TURNING_MOMENT;
    gain_m = RST_RUDDER_GAIN;
    flin_m = RST_FRICTION_LIN;
    fquad_m = RST_FRICTION_QUAD;
    yaw_m = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(680);
    wait_drained();
    if (errors == 0)
      $display("tb_boat_yaw_rate_step_top passed");
    else
      $display("tb_boat_yaw_rate_step_top failed");
    $finish;
  end

endmodule

// ===== boat_yaw_rate_step_top.f =====
rtl/ywr_pkg.sv
rtl/ywr_mul.sv
rtl/ywr_core.sv
rtl/boat_yaw_rate_step_top.sv
bench/tb_boat_yaw_rate_step_top.sv
